// File: hw/rtl/ffra_pkg.sv
// Shared types and constants for the first-fit run allocator.
// Used by ffra_table and first_fit_run_allocator.
package ffra_pkg;

    localparam int START_W = 16;
    localparam int LEN_W   = 17;
    localparam int CAP_W   = 17;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } run_t;

endpackage

// File: hw/rtl/ffra_table.sv
// Free-run table memory: one write port and one registered read port.
// Depends on ffra_pkg for the entry type.
module ffra_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                clk,
    input  logic                we,
    input  logic [AW-1:0]       waddr,
    input  ffra_pkg::run_t      wdata,
    input  logic [AW-1:0]       raddr,
    output ffra_pkg::run_t      rdata
);
    import ffra_pkg::*;

    run_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/first_fit_run_allocator.sv
// First-fit run allocator with bump tail and sorted coalescing free-run table.
// Depends on ffra_pkg and ffra_table.
//
//  channel | valid     | stall     | payload
//  input   | in_valid  | in_stall  | action, run_start, start_present, run_length
//  output  | out_valid | out_stall | granted_start, status
//  config  | cfg_we    | -         | cfg_data (pool_capacity)
//
// One item at a time; the scan visits table entries one by one over the single memory read
// port, and an insert or erase shifts the affected entries one by one through that port.
// Reset clears the run count, the tail and the control; no clearing pass is needed.
// A result waits in the output register while stalled; the next item is taken
// once that result has been transferred.
module first_fit_run_allocator #(
    parameter int POOL_SLOTS    = 65536,
    parameter int MAX_FREE_RUNS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           action,
    input  logic [ffra_pkg::START_W-1:0]   run_start,
    input  logic                           start_present,
    input  logic [ffra_pkg::LEN_W-1:0]     run_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ffra_pkg::START_W-1:0]   granted_start,
    output logic [1:0]                     status,
    input  logic                           cfg_we,
    input  logic [ffra_pkg::CAP_W-1:0]     cfg_data
);
    import ffra_pkg::*;

    localparam int AW = (MAX_FREE_RUNS > 1) ? $clog2(MAX_FREE_RUNS) : 1;
    localparam int CW = $clog2(MAX_FREE_RUNS + 1);
    localparam int TW = $clog2(POOL_SLOTS + 1) > LEN_W ? $clog2(POOL_SLOTS + 1) : LEN_W;
    localparam logic [TW-1:0] SLOTS = TW'(POOL_SLOTS);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_FREE_RUNS);
    localparam logic [LEN_W:0] SATL = {1'b0, {LEN_W{1'b1}}};

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_TRD   = 9'b000000010,
        S_TCHK  = 9'b000000100,
        S_SHRD  = 9'b000001000,
        S_SHWR  = 9'b000010000,
        S_GRD   = 9'b000100000,
        S_GCHK  = 9'b001000000,
        S_GFIN  = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    // Shift modes after a decision.
    typedef enum logic [1:0] {
        SH_ERASE  = 2'd0,
        SH_INSERT = 2'd1,
        SH_TAIL   = 2'd2
    } shift_t;

    state_t state_reg, state_next;
    shift_t sh_reg, sh_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [TW-1:0]      tail_reg, tail_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic               act_reg, act_next;
    logic [START_W-1:0] st_reg, st_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    run_t               prev_reg, prev_next;
    run_t               ins_reg, ins_next;
    logic [START_W-1:0] gs_reg, gs_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    run_t        wdata, rdata;

    ffra_table #(.DEPTH(MAX_FREE_RUNS), .AW(AW)) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic [TW-1:0]  cap_eff;
    logic [TW:0]    tail_sum;
    logic [TW:0]    give_end;
    logic [TW:0]    ent_end;
    logic [LEN_W:0] sum2;
    logic [LEN_W+1:0] sum3;

    assign cap_eff  = (TW'(cap_reg) > SLOTS) ? SLOTS : TW'(cap_reg);
    assign tail_sum = {1'b0, tail_reg} + (TW+1)'(len_reg);
    assign give_end = (TW+1)'(st_reg) + (TW+1)'(len_reg);
    assign ent_end  = (TW+1)'(rdata.start) + (TW+1)'(rdata.len);
    assign sum2     = {1'b0, prev_reg.len} + {1'b0, len_reg};
    assign sum3     = {1'b0, sum2} + (LEN_W+2)'(ins_reg.len);

    assign in_stall      = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign granted_start = gs_reg;
    assign status        = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        sh_next        = sh_reg;
        count_next     = count_reg;
        tail_next      = tail_reg;
        idx_next       = idx_reg;
        act_next       = act_reg;
        st_next        = st_reg;
        len_next       = len_reg;
        prev_next      = prev_reg;
        ins_next       = ins_reg;
        gs_next        = gs_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = ins_reg;
        raddr          = idx_reg[AW-1:0];
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !out_valid_reg)
                begin
                    act_next = action;
                    st_next  = run_start;
                    len_next = run_length;
                    idx_next = '0;
                    gs_next  = '0;
                    if (action == 1'b0)
                    begin
                        state_next = S_TRD;
                    end
                    else if (!start_present || run_length == '0)
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_OUT;
                    end
                    else if ((TW+1)'(run_start) + (TW+1)'(run_length) == {1'b0, tail_reg})
                    begin
                        tail_next  = TW'(run_start);
                        status_next = ST_DONE;
                        if (count_reg == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = count_reg - 1'b1;
                            sh_next    = SH_TAIL;
                            state_next = S_GRD;
                        end
                    end
                    else
                    begin
                        state_next = S_GRD;
                        sh_next    = SH_INSERT;
                    end
                end
            end
            S_TRD:
            begin
                if (idx_reg == count_reg)
                begin
                    if (tail_sum > {1'b0, cap_eff})
                    begin
                        gs_next     = '0;
                        status_next = ST_REFUSED;
                    end
                    else
                    begin
                        gs_next     = tail_reg[START_W-1:0];
                        status_next = ST_DONE;
                        tail_next   = tail_sum[TW-1:0];
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                if (rdata.len < len_reg)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_TRD;
                end
                else
                begin
                    gs_next     = rdata.start;
                    status_next = ST_DONE;
                    if (rdata.len == len_reg)
                    begin
                        count_next = count_reg - 1'b1;
                        sh_next    = SH_ERASE;
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata.start = rdata.start + len_reg[START_W-1:0];
                        wdata.len   = rdata.len - len_reg;
                        state_next  = S_OUT;
                    end
                end
            end
            S_SHRD:
            begin
                // Erase: move entry idx+1 down to idx. Insert: move idx-1 up to idx.
                if (sh_reg == SH_ERASE)
                begin
                    if (idx_reg >= count_reg)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg + 1'b1);
                        state_next = S_SHWR;
                    end
                end
                else
                begin
                    if (idx_reg == prev_reg.start[CW-1:0])
                    begin
                        we         = 1'b1;
                        waddr      = idx_reg[AW-1:0];
                        wdata      = ins_reg;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr      = AW'(idx_reg - 1'b1);
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHWR:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = rdata;
                idx_next   = (sh_reg == SH_ERASE) ? idx_reg + 1'b1 : idx_reg - 1'b1;
                state_next = S_SHRD;
            end
            S_GRD:
            begin
                state_next = S_GCHK;
            end
            S_GCHK:
            begin
                if (sh_reg == SH_TAIL)
                begin
                    if (ent_end == {1'b0, tail_reg})
                    begin
                        tail_next  = TW'(rdata.start);
                        count_next = count_reg - 1'b1;
                        if (idx_reg == '0)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            idx_next   = idx_reg - 1'b1;
                            state_next = S_GRD;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
                else if (idx_reg < count_reg && rdata.start < st_reg)
                begin
                    prev_next  = rdata;
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_GRD;
                end
                else
                begin
                    ins_next   = rdata;
                    state_next = S_GFIN;
                end
            end
            S_GFIN:
            begin
                // ins_reg holds entry at idx (if any), prev_reg entry idx-1 (if any).
                status_next = ST_DONE;
                state_next  = S_OUT;
                if ((idx_reg < count_reg) && (give_end == (TW+1)'(ins_reg.start))
                    && (idx_reg != '0)
                    && ((TW+1)'(prev_reg.start) + (TW+1)'(prev_reg.len) == (TW+1)'(st_reg)))
                begin
                    we          = 1'b1;
                    waddr       = AW'(idx_reg - 1'b1);
                    wdata.start = prev_reg.start;
                    wdata.len   = (sum3 > (LEN_W+2)'(SATL)) ? SATL[LEN_W-1:0]
                                  : sum3[LEN_W-1:0];
                    count_next  = count_reg - 1'b1;
                    sh_next     = SH_ERASE;
                    state_next  = S_SHRD;
                end
                else if ((idx_reg < count_reg) && (give_end == (TW+1)'(ins_reg.start)))
                begin
                    we          = 1'b1;
                    waddr       = idx_reg[AW-1:0];
                    wdata.start = st_reg;
                    wdata.len   = (({1'b0, len_reg} + {1'b0, ins_reg.len}) > SATL)
                                  ? SATL[LEN_W-1:0] : (len_reg + ins_reg.len);
                end
                else if ((idx_reg != '0)
                    && ((TW+1)'(prev_reg.start) + (TW+1)'(prev_reg.len) == (TW+1)'(st_reg)))
                begin
                    we          = 1'b1;
                    waddr       = AW'(idx_reg - 1'b1);
                    wdata.start = prev_reg.start;
                    wdata.len   = (sum2 > SATL) ? SATL[LEN_W-1:0] : sum2[LEN_W-1:0];
                end
                else if (count_reg >= MAXC)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    // Shift entries idx..count-1 up by one, then write the new run.
                    ins_next.start  = st_reg;
                    ins_next.len    = len_reg;
                    prev_next.start = START_W'(idx_reg);
                    idx_next        = count_reg;
                    count_next      = count_reg + 1'b1;
                    sh_next         = SH_INSERT;
                    state_next      = S_SHRD;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_SHRD && sh_reg == SH_ERASE && idx_reg < count_reg)
        begin
            raddr = AW'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sh_reg        <= SH_ERASE;
            cap_reg       <= CAP_W'(65536);
            count_reg     <= '0;
            tail_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sh_reg        <= sh_next;
            count_reg     <= count_next;
            tail_reg      <= tail_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        st_reg     <= st_next;
        len_reg    <= len_next;
        prev_reg   <= prev_next;
        ins_reg    <= ins_next;
        gs_reg     <= gs_next;
        status_reg <= status_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC) else $error("free run count exceeds table depth");

    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !out_valid_reg) |-> !in_stall)
        else $error("idle block stalls input");

    a_take_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !act_reg) |-> (status == ST_DONE || status == ST_REFUSED))
        else $error("take reported a give status");

    a_refuse_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_DONE) |-> granted_start == '0)
        else $error("failed request carries a start");
endmodule
